// ===== rtl/incremental_box_blur_row_top_assert.svh =====
// Assertion macros shared by the box blur row filter.
`ifndef INCREMENTAL_BOX_BLUR_ROW_TOP_ASSERT_SVH
`define INCREMENTAL_BOX_BLUR_ROW_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define IBBR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box blur row: same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define IBBR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box blur row: next-cycle check failed");

`endif

// ===== rtl/ibbr_pkg.sv =====
// Widths and codes shared by the box blur row filter and its channels.
`timescale 1ns / 1ps

package ibbr_pkg;

	// Field widths of the channels and the configuration port.
	localparam int OP_W       = 2;
	localparam int PIX_W      = 8;
	localparam int OCOL_W     = 11;
	localparam int RAD_W      = 4;
	localparam int IWID_W     = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	// Internal arithmetic widths.
	localparam int COL_W = 13;
	localparam int WIN_W = 18;
	localparam int DIA_W = 5;
	localparam int DEN_W = 10;

	typedef logic [OP_W-1:0]      op_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [COL_W-1:0]     col_t;

	// Operation codes of an input beat.
	localparam op_t OP_START      = 2'd0;
	localparam op_t OP_ADD        = 2'd1;
	localparam op_t OP_START_EMIT = 2'd2;
	localparam op_t OP_SLIDE_EMIT = 2'd3;

	// Configuration register indexes.
	localparam cfg_idx_t REG_RADIUS = 1'b0;
	localparam cfg_idx_t REG_WIDTH  = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [RAD_W-1:0]  RADIUS_RST = 4'd1;
	localparam logic [IWID_W-1:0] WIDTH_RST  = 12'h800;

	// Largest vertical column sum.
	localparam col_t COL_MAX = 13'h1FFF;

endpackage

// ===== rtl/ibbr_stream_if.sv =====
// Valid/ready channels for column beats in and blurred pixel beats out.
`timescale 1ns / 1ps

interface ibbr_in_if;
	logic                         valid;
	logic                         ready;
	logic [ibbr_pkg::OP_W-1:0]    operation;
	logic [ibbr_pkg::PIX_W-1:0]   enter_pixel;
	logic [ibbr_pkg::PIX_W-1:0]   leave_pixel;

	modport source (output valid, output operation, output enter_pixel, output leave_pixel,
		input ready);
	modport sink (input valid, input operation, input enter_pixel, input leave_pixel,
		output ready);
endinterface

interface ibbr_out_if;
	logic                         valid;
	logic                         ready;
	logic [ibbr_pkg::PIX_W-1:0]   out_pixel;
	logic [ibbr_pkg::OCOL_W-1:0]  out_column;
	logic                         last_of_row;

	modport source (output valid, output out_pixel, output out_column, output last_of_row,
		input ready);
	modport sink (input valid, input out_pixel, input out_column, input last_of_row,
		output ready);
endinterface

// ===== rtl/incremental_box_blur_row_top.sv =====
// Channel  Dir  Beat payload                           Handshake
// columns  in   operation, enter_pixel, leave_pixel    valid/ready
// pixels   out  out_pixel, out_column, last_of_row     valid/ready
// cfg      in   cfg_index, cfg_data                    cfg_wr_en, no back-pressure
//
// A column beat that emits nothing passes through a read of the column and ring memories,
// then the read-modify-write. An emitting beat goes on to a prepare step and the divider,
// one quotient bit per cycle, which is skipped when the average saturates at 255.
// After reset a clearing pass zeroes all min(MAX_WIDTH, 4095) + 2*min(MAX_RADIUS, 15)
// column memory entries (2078 by default), one per cycle; no column beat is taken then.
// The result sits in an output register, so a stalled pixels channel holds only the next
// emitting beat at its final cycle.
`timescale 1ns / 1ps
`include "incremental_box_blur_row_top_assert.svh"

module incremental_box_blur_row_top #(
	parameter int MAX_RADIUS = 15,
	parameter int MAX_WIDTH  = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [ibbr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ibbr_pkg::CFG_DATA_W-1:0]    cfg_data,
	ibbr_in_if.sink                            columns,
	ibbr_out_if.source                         pixels
);

	// Local names for the package widths so that size casts stay short.
	localparam int PW   = ibbr_pkg::PIX_W;
	localparam int RW   = ibbr_pkg::RAD_W;
	localparam int IW   = ibbr_pkg::IWID_W;
	localparam int CW   = ibbr_pkg::COL_W;
	localparam int WW   = ibbr_pkg::WIN_W;
	localparam int DW   = ibbr_pkg::DIA_W;
	localparam int DENW = ibbr_pkg::DEN_W;
	localparam int OCW  = ibbr_pkg::OCOL_W;
	localparam int SUMW = CW + 1;
	localparam int NUMW = WW + 1;

	// Storage sizes follow the usable radius and width.
	localparam int RAD_CAP    = (MAX_RADIUS < 15) ? MAX_RADIUS : 15;
	localparam int WID_CAP    = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
	localparam int COLS_DEPTH = WID_CAP + 2 * RAD_CAP;
	localparam int ADDR_W     = $clog2(COLS_DEPTH);
	localparam int CNT_W      = $clog2(COLS_DEPTH + 1);
	localparam int RING_DEPTH = 2 * RAD_CAP + 1;
	localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int STEP_W     = $clog2(PW);

	// Sequencer states.
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RMW  = 3'd2;
	localparam logic [2:0] S_PREP = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [RW-1:0]       radius_q;
	logic [IW-1:0]       width_q;
	logic [CNT_W-1:0]    counter_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [WW-1:0]       ws_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;

	logic [ibbr_pkg::OP_W-1:0] op_s1;
	logic [PW-1:0]       enter_s1;
	logic [PW-1:0]       leave_s1;
	logic [CW-1:0]       col_rd_s1;
	logic [CW-1:0]       ring_rd_s1;
	logic [OCW-1:0]      ocol_s2;
	logic                last_s2;
	logic [NUMW-1:0]     rem_q;
	logic [NUMW-1:0]     dsr_q;
	logic [PW-1:0]       quot_q;
	logic [PW-1:0]       pix_q;
	logic [OCW-1:0]      ocol_q;
	logic                last_q;

	logic [CW-1:0]       col_mem [COLS_DEPTH];
	logic [CW-1:0]       ring_mem [RING_DEPTH];

	logic [RW-1:0]       rad_eff;
	logic [IW-1:0]       wid_eff;
	logic [DW-1:0]       dia;
	logic [DW-1:0]       two_r;
	logic [DENW-1:0]     den;
	logic [DENW-2:0]     half;
	logic [CNT_W-1:0]    padded;

	logic                accept;
	logic                out_load;
	logic                is_start;
	logic                is_slide;
	logic                emit;
	logic                c_wrap;
	logic [CNT_W-1:0]    c_inc;
	logic [SUMW-1:0]     sum_up;
	logic [SUMW-1:0]     sub_amt;
	logic [SUMW-1:0]     diff;
	logic [CW-1:0]       col_new;
	logic [WW-1:0]       ws_new;
	logic [NUMW-1:0]     num;
	logic                sat;
	logic                ge;
	logic                col_we;
	logic [ADDR_W-1:0]   col_waddr;
	logic [CW-1:0]       col_wdata;

	// Effective radius, width, window diameter and divisor.
	assign rad_eff = (int'(radius_q) > RAD_CAP) ? RW'(RAD_CAP) : radius_q;
	assign wid_eff = (width_q == '0) ? IW'(1) :
		((int'(width_q) > WID_CAP) ? IW'(WID_CAP) : width_q);
	assign dia     = {rad_eff, 1'b1};
	assign two_r   = {rad_eff, 1'b0};
	assign den     = DENW'(dia) * DENW'(dia);
	// The divisor is odd, so half of it rounded down is a plain shift.
	assign half    = den[DENW-1:1];
	assign padded  = CNT_W'(wid_eff) + CNT_W'(two_r);

	// Handshakes.
	assign columns.ready = (state_q == S_IDLE);
	assign accept        = columns.valid && columns.ready;
	assign out_load      = (state_q == S_OUT) && (!out_valid_q || pixels.ready);

	// Column update: start from the entering pixel, or add and slide with saturation.
	always_comb begin
		is_start = (op_s1 == ibbr_pkg::OP_START) || (op_s1 == ibbr_pkg::OP_START_EMIT);
		is_slide = (op_s1 == ibbr_pkg::OP_SLIDE_EMIT);
		sum_up   = SUMW'(col_rd_s1) + SUMW'(enter_s1);
		sub_amt  = is_slide ? SUMW'(leave_s1) : '0;
		diff     = sum_up - sub_amt;
		if (is_start) begin
			col_new = CW'(enter_s1);
		end else if (sum_up < sub_amt) begin
			col_new = '0;
		end else if (diff > SUMW'(ibbr_pkg::COL_MAX)) begin
			col_new = ibbr_pkg::COL_MAX;
		end else begin
			col_new = diff[CW-1:0];
		end
	end

	// Horizontal window sum over the ring of the last diameter column sums.
	always_comb begin
		if (counter_q == '0) begin
			ws_new = WW'(col_new);
		end else if (counter_q < CNT_W'(dia)) begin
			ws_new = ws_q + WW'(col_new);
		end else begin
			ws_new = ws_q + WW'(col_new) - WW'(ring_rd_s1);
		end
	end

	// Emit decision and column bookkeeping.
	assign emit   = ((op_s1 == ibbr_pkg::OP_START_EMIT) || (op_s1 == ibbr_pkg::OP_SLIDE_EMIT))
		&& (counter_q >= CNT_W'(two_r));
	assign c_inc  = counter_q + CNT_W'(1);
	assign c_wrap = (c_inc >= padded);

	// Rounding numerator and the quotient bit of the current divide step.
	assign num = NUMW'(ws_q) + NUMW'(half);
	assign sat = (num >= (NUMW'(den) << PW));
	assign ge  = (rem_q >= dsr_q);

	// Column memory write port: clearing pass or read-modify-write.
	assign col_we    = (state_q == S_CLR) || (state_q == S_RMW);
	assign col_waddr = (state_q == S_CLR) ? clr_q : counter_q[ADDR_W-1:0];
	assign col_wdata = (state_q == S_CLR) ? '0 : col_new;

	// Column sum memory, read at accept, written in the cycle after.
	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_waddr] <= col_wdata;
		end
		if (accept) begin
			col_rd_s1 <= col_mem[counter_q[ADDR_W-1:0]];
		end
	end

	// Window ring memory, same access pattern at the current slot.
	always_ff @(posedge clk) begin
		if (state_q == S_RMW) begin
			ring_mem[slot_q] <= col_new;
		end
		if (accept) begin
			ring_rd_s1 <= ring_mem[slot_q];
		end
	end

	// Sequencer, scanline position, window sum and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			radius_q    <= ibbr_pkg::RADIUS_RST;
			width_q     <= ibbr_pkg::WIDTH_RST;
			counter_q   <= '0;
			slot_q      <= '0;
			ws_q        <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(COLS_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RMW;
					end
				end
				S_RMW: begin
					ws_q <= ws_new;
					if (c_wrap) begin
						counter_q <= '0;
						slot_q    <= '0;
					end else begin
						counter_q <= c_inc;
						slot_q    <= (slot_q == SLOT_W'(two_r)) ? '0 : slot_q + SLOT_W'(1);
					end
					state_q <= emit ? S_PREP : S_IDLE;
				end
				S_PREP: begin
					step_q  <= STEP_W'(PW - 1);
					state_q <= sat ? S_OUT : S_DIV;
				end
				S_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Output register valid.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end

			// A configuration write restarts the scanline.
			if (cfg_wr_en) begin
				case (cfg_index)
					ibbr_pkg::REG_RADIUS: radius_q <= cfg_data[RW-1:0];
					ibbr_pkg::REG_WIDTH:  width_q  <= cfg_data[IW-1:0];
					default: ;
				endcase
				counter_q <= '0;
				slot_q    <= '0;
				ws_q      <= '0;
			end
		end
	end

	// Beat payload, divider datapath and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= columns.operation;
			enter_s1 <= columns.enter_pixel;
			leave_s1 <= columns.leave_pixel;
		end
		if (state_q == S_RMW) begin
			ocol_s2 <= OCW'(counter_q - CNT_W'(two_r));
			last_s2 <= c_wrap;
		end
		case (state_q)
			S_PREP: begin
				rem_q  <= num;
				dsr_q  <= NUMW'(den) << (PW - 1);
				quot_q <= sat ? '1 : '0;
			end
			S_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsr_q;
				end
				dsr_q  <= dsr_q >> 1;
				quot_q <= {quot_q[PW-2:0], ge};
			end
			default: ;
		endcase
		if (out_load) begin
			pix_q  <= quot_q;
			ocol_q <= ocol_s2;
			last_q <= last_s2;
		end
	end

	assign pixels.valid       = out_valid_q;
	assign pixels.out_pixel   = pix_q;
	assign pixels.out_column  = ocol_q;
	assign pixels.last_of_row = last_q;

	// The column position never runs past the padded scanline.
	`IBBR_ASSERT_IMP(a_cnt_range, 1'b1, counter_q < padded)
	// While the ring is filling, the ring slot tracks the column position.
	`IBBR_ASSERT_IMP(a_slot_fill, counter_q < CNT_W'(dia), CNT_W'(slot_q) == counter_q)
	// An accepted beat goes straight into its read-modify-write.
	`IBBR_ASSERT_NXT(a_accept_rmw, columns.valid && columns.ready, state_q == S_RMW)
	// Nothing moves on the channels during the clearing pass.
	`IBBR_ASSERT_IMP(a_clear_quiet, state_q == S_CLR, !columns.ready && !pixels.valid)
	// The partial remainder stays below twice the shifted divisor.
	`IBBR_ASSERT_IMP(a_div_bound, state_q == S_DIV, rem_q < (dsr_q << 1))

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the box blur row filter: directed and random column beats.
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_W       = 2048;
	localparam int MAX_R       = 15;
	localparam int COLS_DEPTH  = MAX_W + 2 * MAX_R;
	localparam int RING_DEPTH  = 2 * MAX_R + 1;
	localparam int ITEM_TARGET = 1050;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_LEN    = 600;

	// Local names for the package widths.
	localparam int PIX_W      = ibbr_pkg::PIX_W;
	localparam int OCOL_W     = ibbr_pkg::OCOL_W;
	localparam int RAD_W      = ibbr_pkg::RAD_W;
	localparam int IWID_W     = ibbr_pkg::IWID_W;
	localparam int CFG_IDX_W  = ibbr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = ibbr_pkg::CFG_DATA_W;
	localparam int WIN_W      = ibbr_pkg::WIN_W;

	typedef struct {
		ibbr_pkg::op_t    op;
		logic [PIX_W-1:0] enter;
		logic [PIX_W-1:0] leave;
	} col_beat_t;

	typedef struct {
		logic [PIX_W-1:0]  pix;
		logic [OCOL_W-1:0] col;
		logic              last;
	} blur_px_t;

	// Shapes of one pass over the padded columns of a scanline.
	typedef enum {
		PASS_START, PASS_ADD, PASS_START_EMIT, PASS_SLIDE, PASS_FINISH, PASS_NOISE
	} pass_kind_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ibbr_in_if  cols ();
	ibbr_out_if px ();

	incremental_box_blur_row_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.columns   (cols),
		.pixels    (px)
	);

	// Shadow of the block: configuration, column memory, window ring and counters.
	logic [RAD_W-1:0]  cur_radius;
	logic [IWID_W-1:0] cur_width;
	ibbr_pkg::col_t    column_totals [COLS_DEPTH];
	ibbr_pkg::col_t    ring [RING_DEPTH];
	logic [WIN_W-1:0]  win_total;
	int unsigned       scan_pos;

	col_beat_t column_beats_q [$];
	blur_px_t  blurred_px_q [$];

	int  in_count;
	int  queued;
	int  err_count;
	int  cycles;
	int  hold_left;
	bit  hold_used;
	bit  in_took;

	always #2 clk = ~clk;

	function automatic int unsigned padded_cols();
		int unsigned w;
		if (cur_width == 0)
			w = 1;
		else if (cur_width > MAX_W)
			w = MAX_W;
		else
			w = cur_width;
		return w + 2 * cur_radius;
	endfunction

	// Running-sum blur of one column beat; queues the averaged pixel when one is due.
	function automatic void blur_column(col_beat_t b);
		int unsigned r, d, padded, c, slot, den, q;
		int v;
		blur_px_t exp_px;
		r = cur_radius;
		d = 2 * r + 1;
		padded = padded_cols();
		c = scan_pos;
		if (c >= padded || c >= COLS_DEPTH)
			c = 0;

		// Vertical sum, saturated to the column width.
		if (b.op == ibbr_pkg::OP_START || b.op == ibbr_pkg::OP_START_EMIT) begin
			v = int'(b.enter);
		end else begin
			v = int'(column_totals[c]) + int'(b.enter);
			if (b.op == ibbr_pkg::OP_SLIDE_EMIT)
				v = v - int'(b.leave);
			if (v < 0)
				v = 0;
			if (v > int'(ibbr_pkg::COL_MAX))
				v = int'(ibbr_pkg::COL_MAX);
		end
		column_totals[c] = ibbr_pkg::col_t'(v);

		// Horizontal window over the last d column sums.
		slot = c % d;
		if (c == 0)
			win_total = WIN_W'(v);
		else if (c < d)
			win_total = WIN_W'(int'(win_total) + v);
		else
			win_total = WIN_W'(int'(win_total) + v - int'(ring[slot]));
		ring[slot] = ibbr_pkg::col_t'(v);

		if ((b.op == ibbr_pkg::OP_START_EMIT || b.op == ibbr_pkg::OP_SLIDE_EMIT)
			&& c >= 2 * r) begin
			den = d * d;
			q = (win_total + den / 2) / den;
			if (q > 255)
				q = 255;
			exp_px.pix = PIX_W'(q);
			exp_px.col = OCOL_W'(c - 2 * r);
			exp_px.last = (c + 1 == padded);
			blurred_px_q.push_back(exp_px);
		end

		scan_pos = (c + 1 >= padded) ? 0 : c + 1;
	endfunction

	function automatic int tx_idle_pct();
		if (in_count < ITEM_TARGET / 3)
			return 24;
		else if (in_count < 2 * ITEM_TARGET / 3)
			return 88;
		return 0;
	endfunction

	function automatic int rx_idle_pct();
		if (in_count < ITEM_TARGET / 3)
			return 88;
		else if (in_count < 2 * ITEM_TARGET / 3)
			return 24;
		return 0;
	endfunction

	function automatic logic [PIX_W-1:0] any_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Column beat driver: holds a beat until it is taken, idles only between beats.
	always @(negedge clk) begin : drive_columns
		col_beat_t nb;
		bit give;
		if (!arst_n) begin
			cols.valid <= 1'b0;
		end else if (!cols.valid || in_took) begin
			give = column_beats_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct();
			if (give) begin
				nb = column_beats_q.pop_front();
				cols.valid <= 1'b1;
				cols.operation <= nb.op;
				cols.enter_pixel <= nb.enter;
				cols.leave_pixel <= nb.leave;
			end else begin
				cols.valid <= 1'b0;
			end
		end
	end

	// Pixel receiver: random stalls, plus one long hold-off to back up the block.
	always @(negedge clk) begin
		px.ready <= arst_n && hold_left == 0 && $urandom_range(0, 99) >= rx_idle_pct();
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && in_count >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_used <= 1'b1;
		end
	end

	// Monitor: register writes, accepted column beats and pixel beat checks.
	always @(posedge clk) begin : watch_ports
		blur_px_t got_px;
		blur_px_t exp_px;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= cols.valid && cols.ready;
			if (cfg_wr_en) begin
				if (cfg_index == ibbr_pkg::REG_RADIUS)
					cur_radius = cfg_data[RAD_W-1:0];
				else if (cfg_index == ibbr_pkg::REG_WIDTH)
					cur_width = cfg_data[IWID_W-1:0];
				scan_pos = 0;
				win_total = '0;
			end
			if (px.valid && px.ready) begin
				got_px.pix = px.out_pixel;
				got_px.col = px.out_column;
				got_px.last = px.last_of_row;
				if (blurred_px_q.size() == 0) begin
					$error("pixel beat with nothing expected: out_column %0d", got_px.col);
					err_count++;
				end else begin
					exp_px = blurred_px_q.pop_front();
					if (got_px.pix !== exp_px.pix) begin
						$error("out_pixel: expected %0d, got %0d", exp_px.pix, got_px.pix);
						err_count++;
					end
					if (got_px.col !== exp_px.col) begin
						$error("out_column: expected %0d, got %0d", exp_px.col, got_px.col);
						err_count++;
					end
					if (got_px.last !== exp_px.last) begin
						$error("last_of_row: expected %0d, got %0d", exp_px.last, got_px.last);
						err_count++;
					end
				end
			end
			if (cols.valid && cols.ready) begin
				blur_column('{cols.operation, cols.enter_pixel, cols.leave_pixel});
				in_count <= in_count + 1;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("incremental_box_blur_row_top: mismatch");
			$finish;
		end
	end

	task automatic write_reg(ibbr_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_beat(ibbr_pkg::op_t op, logic [PIX_W-1:0] enter,
		logic [PIX_W-1:0] leave);
		column_beats_q.push_back('{op, enter, leave});
		queued++;
	endtask

	task automatic queue_pass(pass_kind_t kind, int n, bit bright);
		col_beat_t b;
		for (int i = 0; i < n; i++) begin
			b.enter = bright ? PIX_W'($urandom_range(200, 255)) : any_pixel();
			b.leave = any_pixel();
			case (kind)
				PASS_START: b.op = ibbr_pkg::OP_START;
				PASS_ADD: b.op = ibbr_pkg::OP_ADD;
				PASS_START_EMIT: b.op = ibbr_pkg::OP_START_EMIT;
				PASS_SLIDE: b.op = ibbr_pkg::OP_SLIDE_EMIT;
				PASS_FINISH: begin
					b.op = ibbr_pkg::OP_SLIDE_EMIT;
					b.leave = '0;
				end
				default: b.op = ibbr_pkg::op_t'($urandom_range(0, 3));
			endcase
			column_beats_q.push_back(b);
		end
		queued += n;
	endtask

	// Waits until every beat is taken and every pixel has come, then lets the block settle.
	task automatic drain();
		while (column_beats_q.size() != 0 || cols.valid || blurred_px_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned p;
		int phase_no;
		int rad, wid, pick;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cols.valid = 1'b0;
		cols.operation = ibbr_pkg::OP_START;
		cols.enter_pixel = '0;
		cols.leave_pixel = '0;
		px.ready = 1'b0;
		cur_radius = ibbr_pkg::RADIUS_RST;
		cur_width = ibbr_pkg::WIDTH_RST;
		foreach (column_totals[i])
			column_totals[i] = '0;
		foreach (ring[i])
			ring[i] = '0;
		win_total = '0;
		scan_pos = 0;
		in_count = 0;
		queued = 0;
		err_count = 0;
		cycles = 0;
		hold_left = 0;
		hold_used = 1'b0;
		in_took = 1'b0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		// The column memory clears itself before the first beat is taken.
		@(posedge clk);
		while (!cols.ready)
			@(posedge clk);

		// Radius 0 with junk in the upper data bits, width 0: one column per scanline.
		write_reg(ibbr_pkg::REG_RADIUS, 12'hFF0);
		write_reg(ibbr_pkg::REG_WIDTH, 12'd0);
		@(posedge clk);
		queue_beat(ibbr_pkg::OP_START, 8'd255, 8'd0);
		queue_beat(ibbr_pkg::OP_ADD, 8'd255, 8'd255);
		queue_beat(ibbr_pkg::OP_SLIDE_EMIT, 8'd255, 8'd0);
		queue_beat(ibbr_pkg::OP_SLIDE_EMIT, 8'd0, 8'd255);
		queue_beat(ibbr_pkg::OP_START_EMIT, 8'd0, 8'd255);
		queue_beat(ibbr_pkg::OP_SLIDE_EMIT, 8'd0, 8'd255);
		queue_beat(ibbr_pkg::OP_START_EMIT, 8'd255, 8'd0);
		queue_beat(ibbr_pkg::OP_ADD, 8'd1, 8'd0);
		queue_beat(ibbr_pkg::OP_SLIDE_EMIT, 8'd0, 8'd0);
		drain();

		// Radius 2, width 3: the first four columns fill the window and emit nothing.
		write_reg(ibbr_pkg::REG_RADIUS, 12'd2);
		write_reg(ibbr_pkg::REG_WIDTH, 12'd3);
		@(posedge clk);
		for (int i = 0; i < 7; i++)
			queue_beat(ibbr_pkg::OP_START_EMIT, (i % 2) ? 8'd255 : 8'd0, 8'd255);
		drain();

		phase_no = 0;
		while (queued < ITEM_TARGET) begin
			if (phase_no == 0) begin
				// A tall column: bright rows pile up until the column sum saturates.
				write_reg(ibbr_pkg::REG_RADIUS, 12'd0);
				write_reg(ibbr_pkg::REG_WIDTH, 12'($urandom_range(1, 2)));
				@(posedge clk);
				p = padded_cols();
				queue_pass(PASS_START, p, 1'b1);
				repeat (36) queue_pass(PASS_ADD, p, 1'b1);
				queue_pass(PASS_FINISH, p, 1'b0);
			end else if (phase_no == 1) begin
				// Full width, largest radius; the scanline is cut short by the next write.
				write_reg(ibbr_pkg::REG_RADIUS, 12'd15);
				write_reg(ibbr_pkg::REG_WIDTH, 12'd2048);
				@(posedge clk);
				queue_pass(PASS_SLIDE, 90, 1'b0);
			end else if (phase_no == 2) begin
				// Width beyond the column memory acts as the largest width.
				write_reg(ibbr_pkg::REG_RADIUS, 12'h5F0);
				write_reg(ibbr_pkg::REG_WIDTH, 12'hFFF);
				@(posedge clk);
				queue_pass(PASS_START_EMIT, 40, 1'b0);
			end else begin
				pick = $urandom_range(0, 4);
				rad = (pick == 0) ? 0 : (pick == 1) ? 15 : $urandom_range(0, 15);
				wid = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
				write_reg(ibbr_pkg::REG_RADIUS, {8'($urandom_range(0, 255)), 4'(rad)});
				if ($urandom_range(0, 3) != 0)
					write_reg(ibbr_pkg::REG_WIDTH, 12'(wid));
				@(posedge clk);
				p = padded_cols();
				// Mostly whole scanline passes in a sensible order, some noise and cut passes.
				repeat ($urandom_range(2, 5)) begin
					if (queued >= ITEM_TARGET)
						break;
					pick = $urandom_range(0, 9);
					if (pick <= 3) begin
						queue_pass(PASS_START, p, 1'b0);
						repeat ($urandom_range(0, 3)) queue_pass(PASS_ADD, p, 1'b0);
						queue_pass(PASS_FINISH, p, 1'b0);
					end else if (pick <= 5) begin
						repeat ($urandom_range(1, 3)) queue_pass(PASS_SLIDE, p, 1'b0);
					end else if (pick == 6) begin
						queue_pass(PASS_START_EMIT, p, 1'b0);
					end else if (pick == 7) begin
						queue_pass(pass_kind_t'($urandom_range(0, 5)),
							$urandom_range(1, p), 1'b0);
					end else begin
						queue_pass(PASS_NOISE, p, 1'b0);
					end
				end
			end
			drain();
			phase_no++;
		end

		@(negedge clk);
		if (err_count == 0 && blurred_px_q.size() == 0)
			$display("incremental_box_blur_row_top: match");
		else
			$display("incremental_box_blur_row_top: mismatch");
		$finish;
	end

endmodule
